FILE: rtl/rtcbr_pkg.sv
// Shared types and constants for the clock and battery RAM command port.
// Used by rtcbr_seq and rtc_battery_ram_command_port_unit; depends on nothing.
`default_nettype none

package rtcbr_pkg;

   // Battery RAM geometry.
   localparam int RAM_DEPTH  = 256;
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

   // Bus access codes.
   localparam logic FUNC_READ   = 1'b0;
   localparam logic FUNC_WRITE  = 1'b1;
   localparam logic REG_DATA    = 1'b0;
   localparam logic REG_CONTROL = 1'b1;

   // Command byte decode.
   localparam logic [7:0] CMD_RAM_MASK  = 8'h78;
   localparam logic [7:0] CMD_RAM_MATCH = 8'h38;
   localparam logic [7:0] CMD_CLK_MASK  = 8'h73;
   localparam logic [7:0] CMD_CLK_MATCH = 8'h01;

   // Sequencer codes (low seven bits; bit 7 carries the read flag).
   localparam logic [6:0] SEQ_RAM_START = 7'h41;
   localparam logic [6:0] SEQ_CLK_START = 7'h02;
   localparam logic [7:0] SEQ_IDLE      = 8'h00;

   // Sequencer phases held in the low nibble.
   localparam logic [3:0] PHASE_IDLE   = 4'd0;
   localparam logic [3:0] PHASE_ADDR   = 4'd1;
   localparam logic [3:0] PHASE_ACCESS = 4'd2;

   // Control register masks.
   localparam logic [7:0] ADDR_LO_MASK = 8'h1F;
   localparam logic [7:0] CTRL_MASK    = 8'hF0;
   localparam logic [7:0] CTRL_KEEP    = 8'h7F;
   localparam logic [7:0] CTRL_HOLD    = 8'h20;

   // Sequencer-visible state.
   typedef struct packed {
      logic [7:0]  seq_state;
      logic [7:0]  target;
      logic [7:0]  data;
      logic [31:0] latched;
   } core_state_type;

   // Battery RAM access requested by one control write.
   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [RAM_ADDR_W-1:0] addr;
      logic [7:0]            wr_data;
   } ram_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/rtcbr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rtcbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rtcbr_seq.sv
// Next-state logic of the command sequencer for one control register write.
// Depends on rtcbr_pkg.
`default_nettype none

module rtcbr_seq (
   input  wire rtcbr_pkg::core_state_type cur,
   input  wire logic [7:0]                write_data,
   input  wire logic [31:0]               seconds_now,
   input  wire logic [31:0]               clock_offset,
   output rtcbr_pkg::core_state_type      nxt,
   output rtcbr_pkg::ram_cmd_type         ram_cmd
);
   import rtcbr_pkg::*;

   logic [7:0]  data_val;
   logic [31:0] seconds_sum;
   logic [31:0] latch_use;

   assign seconds_sum = seconds_now + clock_offset;

   always_comb begin
      // The data register survives only when control bit 5 is written set.
      data_val  = ((write_data & CTRL_HOLD) != 8'h00) ? cur.data : 8'h00;
      latch_use = cur.latched;
      nxt       = cur;
      nxt.data  = data_val;
      ram_cmd.rd_en   = 1'b0;
      ram_cmd.wr_en   = 1'b0;
      ram_cmd.addr    = cur.target[RAM_ADDR_W-1:0];
      ram_cmd.wr_data = data_val;

      case (cur.seq_state[3:0])
         PHASE_IDLE: begin
            if ((data_val & CMD_RAM_MASK) == CMD_RAM_MATCH) begin
               nxt.seq_state = {data_val[7], SEQ_RAM_START};
               nxt.target    = {data_val[2:0], 5'b0_0000};
            end else if ((data_val & CMD_CLK_MASK) == CMD_CLK_MATCH) begin
               nxt.seq_state = {data_val[7], SEQ_CLK_START};
               nxt.target    = {6'b00_0000, data_val[3:2]};
            end
         end
         PHASE_ADDR: begin
            nxt.target    = cur.target | ({2'b00, data_val[7:2]} & ADDR_LO_MASK);
            nxt.seq_state = cur.seq_state + 8'd1;
         end
         PHASE_ACCESS: begin
            if (cur.seq_state[6]) begin
               ram_cmd.rd_en = cur.seq_state[7];
               ram_cmd.wr_en = !cur.seq_state[7];
            end else if (cur.seq_state[7]) begin
               // Clock byte read; byte 0 takes a fresh snapshot.
               if (cur.target == 8'h00) begin
                  latch_use = seconds_sum;
               end
               nxt.latched = latch_use;
               nxt.data    = 8'(latch_use >> {cur.target[1:0], 3'b000});
            end
            nxt.seq_state = SEQ_IDLE;
         end
         default: begin
            nxt.seq_state = SEQ_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/rtc_battery_ram_command_port_unit.sv
// Top level of the clock and battery RAM command port.
// Depends on rtcbr_pkg, rtcbr_seq and rtcbr_ram.
`default_nettype none

// The unit accepts one bus request per clock cycle while req_stall is low,
// and returns exactly one response byte for each request, in the cycle after
// acceptance at the earliest. A request writes or reads either the clock data
// register or the clock control and border register; control writes drive the
// command sequencer, which reaches the 256-byte battery RAM or the latched
// seconds counter. The battery RAM sits in a synchronous memory with a
// registered read. A RAM read step loads the data register from the memory
// output register, which the following request picks up directly, so
// back-to-back requests never wait for the memory. After reset a clearing pass
// writes zero to one battery RAM entry per cycle; req_stall stays high until
// the pass ends, and only then is the first request accepted.
// The response path holds a two-entry output buffer; after the clearing pass
// req_stall rises only when both entries are full. The clock offset register
// may be written at any time the unit is idle and takes effect for the next
// clock snapshot.
module rtc_battery_ram_command_port_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic        req_reg_select,
   input  wire logic [7:0]  req_write_data,
   input  wire logic [31:0] req_seconds_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data
);
   import rtcbr_pkg::*;

   // Configuration.
   logic [31:0] offset_ff;

   // Architectural registers.
   logic [7:0]  data_ff, data_in;
   logic        pend_ff, pend_in;      // data register lives in the RAM output
   logic [7:0]  ctrl_ff;
   logic [3:0]  border_ff;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  target_ff, target_in;
   logic [31:0] latched_ff, latched_in;

   // Battery RAM clearing pass after reset.
   logic                  clear_ff;
   logic [RAM_ADDR_W-1:0] clear_addr_ff;

   // Response buffer.
   logic        rsp_valid_ff, skid_valid_ff;
   logic [7:0]  rsp_data_ff, skid_data_ff;

   logic                  accept;
   logic                  ctrl_write;
   logic                  out_fire;
   logic [7:0]            data_eff;
   logic [7:0]            ram_rdata;
   logic [7:0]            result;
   core_state_type        cur_state;
   core_state_type        nxt_state;
   ram_cmd_type           ram_cmd;
   logic                  ram_wr;
   logic                  ram_rd;
   logic [RAM_ADDR_W-1:0] ram_addr;
   logic [7:0]            ram_wdata;

   assign req_stall     = skid_valid_ff || clear_ff;
   assign accept        = req_valid && !req_stall;
   assign out_fire      = rsp_valid_ff && !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign ctrl_write    = accept && (req_func == FUNC_WRITE) && (req_reg_select == REG_CONTROL);

   // The data register as the model sees it: forwarded from the RAM after a
   // RAM read step.
   assign data_eff = pend_ff ? ram_rdata : data_ff;

   assign cur_state.seq_state = seq_ff;
   assign cur_state.target    = target_ff;
   assign cur_state.data      = data_eff;
   assign cur_state.latched   = latched_ff;

   rtcbr_seq u_seq (
      .cur          (cur_state),
      .write_data   (req_write_data),
      .seconds_now  (req_seconds_now),
      .clock_offset (offset_ff),
      .nxt          (nxt_state),
      .ram_cmd      (ram_cmd)
   );

   // The clearing pass owns the write port until every entry holds zero.
   assign ram_wr    = !reset && (clear_ff || (ctrl_write && ram_cmd.wr_en));
   assign ram_rd    = ctrl_write && ram_cmd.rd_en && !reset;
   assign ram_addr  = clear_ff ? clear_addr_ff : ram_cmd.addr;
   assign ram_wdata = clear_ff ? 8'h00 : ram_cmd.wr_data;

   rtcbr_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // Reads have no side effect; writes always answer zero.
   always_comb begin
      if (req_func == FUNC_WRITE) begin
         result = 8'h00;
      end else if (req_reg_select == REG_DATA) begin
         result = data_eff;
      end else begin
         result = ctrl_ff | {4'h0, border_ff};
      end
   end

   // Next values of the sequencer-visible state.
   always_comb begin
      data_in    = data_eff;
      pend_in    = pend_ff;
      seq_in     = seq_ff;
      target_in  = target_ff;
      latched_in = latched_ff;
      if (accept && (req_func == FUNC_WRITE)) begin
         if (req_reg_select == REG_DATA) begin
            data_in = req_write_data;
            pend_in = 1'b0;
         end else begin
            data_in    = nxt_state.data;
            pend_in    = ram_cmd.rd_en;
            seq_in     = nxt_state.seq_state;
            target_in  = nxt_state.target;
            latched_in = nxt_state.latched;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= 32'h0000_0000;
         data_ff       <= 8'h00;
         pend_ff       <= 1'b0;
         ctrl_ff       <= 8'h00;
         border_ff     <= 4'h0;
         seq_ff        <= SEQ_IDLE;
         target_ff     <= 8'h00;
         latched_ff    <= 32'h0000_0000;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            offset_ff <= csr_write_data;
         end

         // One entry is cleared per cycle; the last entry ends the pass.
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == RAM_ADDR_W'(RAM_DEPTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end

         data_ff    <= data_in;
         pend_ff    <= pend_in;
         seq_ff     <= seq_in;
         target_ff  <= target_in;
         latched_ff <= latched_in;

         if (ctrl_write) begin
            border_ff <= req_write_data[3:0];
            // The transaction bit never survives a control write.
            ctrl_ff   <= req_write_data & CTRL_MASK & CTRL_KEEP;
         end

         // Two-entry response buffer.
         if (skid_valid_ff) begin
            if (out_fire) begin
               rsp_data_ff   <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!rsp_valid_ff || out_fire) begin
               rsp_data_ff  <= result;
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_data_ff  <= result;
               skid_valid_ff <= 1'b1;
            end
         end else if (out_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/rtc_battery_ram_command_port_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the clock and battery RAM command port unit.
// Depends on rtcbr_pkg and the unit's RTL.

module rtc_battery_ram_command_port_unit_tb;
   import rtcbr_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 500;
   localparam int unsigned CYCLE_LIMIT     = 400_000;

   // One bus request. When pinned is set, the response byte is fixed by hand
   // and the predictor only has to keep its state in step.
   typedef struct packed {
      logic        func;
      logic        sel;
      logic [7:0]  wdata;
      logic [31:0] seconds;
      logic        pinned;
      logic [7:0]  pinned_byte;
   } bus_request_type;

   // Every input of the unit starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_func = FUNC_READ;
   logic        req_reg_select = REG_DATA;
   logic [7:0]  req_write_data = '0;
   logic [31:0] req_seconds_now = '0;
   logic        rsp_stall = 1'b0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [7:0]  rsp_read_data;

   // Side information that travels with the request on the bus.
   logic        req_pinned = 1'b0;
   logic [7:0]  req_pinned_byte = '0;

   // Shadow copy of the unit's architectural state.
   logic [7:0]  shadow_data = '0;
   logic [7:0]  shadow_control = '0;
   logic [3:0]  shadow_border = '0;
   logic [7:0]  shadow_sequencer = SEQ_IDLE;
   logic [7:0]  shadow_target = '0;
   logic [31:0] shadow_seconds = '0;
   logic [31:0] shadow_offset = '0;
   logic [7:0]  shadow_ram [RAM_DEPTH];

   logic [7:0]  expected_read_bytes [$];
   int unsigned requests_accepted = 0;
   int unsigned requests_sent = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   bus_request_type directed_requests [28];

   rtc_battery_ram_command_port_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_reg_select   (req_reg_select),
      .req_write_data   (req_write_data),
      .req_seconds_now  (req_seconds_now),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Applies one accepted request to the shadow state and returns the byte
   // that the unit must send back for it. Control writes step the command
   // sequencer after the data register has possibly been cleared.
   function automatic logic [7:0] predict_read_byte(input logic func, input logic sel,
                                                   input logic [7:0] wdata,
                                                   input logic [31:0] seconds);
      logic [7:0] result;
      result = 8'h00;
      if (func == FUNC_WRITE) begin
         if (sel == REG_DATA) begin
            shadow_data = wdata;
         end else begin
            shadow_border = wdata[3:0];
            shadow_control = wdata & CTRL_MASK;
            if ((shadow_control & CTRL_HOLD) == 8'h00) begin
               shadow_data = 8'h00;
            end
            case (shadow_sequencer[3:0])
               PHASE_IDLE: begin
                  if ((shadow_data & CMD_RAM_MASK) == CMD_RAM_MATCH) begin
                     shadow_sequencer = {shadow_data[7], SEQ_RAM_START};
                     shadow_target = {shadow_data[2:0], 5'b00000};
                  end else if ((shadow_data & CMD_CLK_MASK) == CMD_CLK_MATCH) begin
                     shadow_sequencer = {shadow_data[7], SEQ_CLK_START};
                     shadow_target = {6'b000000, shadow_data[3:2]};
                  end
               end
               PHASE_ADDR: begin
                  shadow_target = shadow_target | ((shadow_data >> 2) & ADDR_LO_MASK);
                  shadow_sequencer = shadow_sequencer + 8'd1;
               end
               PHASE_ACCESS: begin
                  // Bit 6 marks a RAM access, bit 7 a read. A clock write does nothing.
                  if (shadow_sequencer[6]) begin
                     if (shadow_sequencer[7]) begin
                        shadow_data = shadow_ram[shadow_target];
                     end else begin
                        shadow_ram[shadow_target] = shadow_data;
                     end
                  end else if (shadow_sequencer[7]) begin
                     if (shadow_target == 8'h00) begin
                        shadow_seconds = seconds + shadow_offset;
                     end
                     shadow_data = 8'(shadow_seconds >> (8 * shadow_target[1:0]));
                  end
                  shadow_sequencer = SEQ_IDLE;
               end
               default: begin
                  shadow_sequencer = SEQ_IDLE;
               end
            endcase
            shadow_control = shadow_control & CTRL_KEEP;
         end
      end else if (sel == REG_DATA) begin
         result = shadow_data;
      end else begin
         result = shadow_control | {4'h0, shadow_border};
      end
      return result;
   endfunction

   task automatic log_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected %02h, got %02h", $time, what, want, got);
      end
   endtask

   // Everything is sampled at the rising edge, before the unit's own updates
   // of that edge land. Responses are checked before new requests are queued;
   // a request can never be answered in the cycle that accepts it.
   always @(posedge clock) begin
      logic [7:0] predicted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_read_bytes.size() == 0) begin
               log_mismatch("response with no request outstanding", 8'h00, rsp_read_data);
            end else if (rsp_read_data !== expected_read_bytes[0]) begin
               log_mismatch("read_data", expected_read_bytes[0], rsp_read_data);
               void'(expected_read_bytes.pop_front());
            end else begin
               void'(expected_read_bytes.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            predicted = predict_read_byte(req_func, req_reg_select, req_write_data,
                                          req_seconds_now);
            expected_read_bytes.push_back(req_pinned ? req_pinned_byte : predicted);
            requests_accepted++;
         end
         if (csr_write_enable) begin
            shadow_offset = csr_write_data;
         end
      end
   end

   // The receiver stalls at random at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Presents one request after a random gap and holds it until accepted.
   // Valid is lowered here only inside a gap, so back-to-back requests keep it high.
   task automatic send_request(input bus_request_type r);
      int unsigned target;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      target = requests_accepted + 1;
      req_func <= r.func;
      req_reg_select <= r.sel;
      req_write_data <= r.wdata;
      req_seconds_now <= r.seconds;
      req_pinned <= r.pinned;
      req_pinned_byte <= r.pinned_byte;
      req_valid <= 1'b1;
      do @(negedge clock); while (requests_accepted != target);
      requests_sent++;
   endtask

   // A random access checked by the predictor. Now and then a read of either
   // register is slipped in first; reads change nothing, so sequences stay intact.
   task automatic bus_access(input logic func, input logic sel, input logic [7:0] wdata,
                             input logic [31:0] seconds);
      bus_request_type r;
      if ($urandom_range(4) == 0) begin
         r = '{FUNC_READ, 1'($urandom), 8'($urandom), $urandom, 1'b0, 8'h00};
         send_request(r);
      end
      r = '{func, sel, wdata, seconds, 1'b0, 8'h00};
      send_request(r);
   endtask

   // Stops sending until every outstanding response has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_read_bytes.size() != 0);
   endtask

   function automatic logic [7:0] control_with_hold();
      return 8'($urandom) | CTRL_HOLD;
   endfunction

   // Full battery RAM transaction: command, address low bits, then the access.
   // Every control write but the last one of a read keeps the data register so the sequence survives.
   task automatic battery_ram_access(input logic read_back, input logic [7:0] addr);
      bus_access(FUNC_WRITE, REG_DATA, CMD_RAM_MATCH | {read_back, 4'b0000, addr[7:5]},
                 $urandom);
      bus_access(FUNC_WRITE, REG_CONTROL, control_with_hold(), $urandom);
      bus_access(FUNC_WRITE, REG_DATA, {1'($urandom), addr[4:0], 2'($urandom)}, $urandom);
      bus_access(FUNC_WRITE, REG_CONTROL, control_with_hold(), $urandom);
      if (!read_back) begin
         bus_access(FUNC_WRITE, REG_DATA, 8'($urandom), $urandom);
      end
      bus_access(FUNC_WRITE, REG_CONTROL, read_back ? 8'($urandom) : control_with_hold(),
                 $urandom);
      if (read_back) begin
         bus_access(FUNC_READ, REG_DATA, 8'($urandom), $urandom);
      end
   endtask

   // Clock byte transaction. Byte 0 reads take a fresh snapshot of the time
   // input, which is pushed to its extremes now and then.
   task automatic clock_byte_access(input logic read_back, input logic [1:0] index);
      logic [31:0] seconds;
      case ($urandom_range(5))
         0: seconds = 32'hFFFF_FFFF;
         1: seconds = 32'h0000_0000;
         default: seconds = $urandom;
      endcase
      bus_access(FUNC_WRITE, REG_DATA, CMD_CLK_MATCH | {read_back, 3'b000, index, 2'b00},
                 $urandom);
      bus_access(FUNC_WRITE, REG_CONTROL, control_with_hold(), $urandom);
      bus_access(FUNC_WRITE, REG_CONTROL, control_with_hold(), seconds);
      bus_access(FUNC_READ, REG_DATA, 8'($urandom), $urandom);
   endtask

   task automatic program_clock_offset(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned phase_end;
      logic [7:0]  addr;
      logic [31:0] offset;

      foreach (shadow_ram[i]) begin
         shadow_ram[i] = 8'h00;
      end

      // Directed opening. Pinned rows are obvious from reset values and the
      // register layout; the rest lean on the predictor.
      directed_requests = '{
         '{FUNC_READ,  REG_DATA,    8'h00, 32'h0, 1'b1, 8'h00}, // data after reset
         '{FUNC_READ,  REG_CONTROL, 8'h00, 32'h0, 1'b1, 8'h00}, // control after reset
         '{FUNC_WRITE, REG_DATA,    8'hFF, 32'h0, 1'b1, 8'h00}, // writes return zero
         '{FUNC_READ,  REG_DATA,    8'h00, 32'h0, 1'b1, 8'hFF},
         '{FUNC_WRITE, REG_CONTROL, 8'h0F, 32'h0, 1'b1, 8'h00}, // clears data, no command
         '{FUNC_READ,  REG_CONTROL, 8'h00, 32'h0, 1'b1, 8'h0F},
         '{FUNC_READ,  REG_DATA,    8'h00, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_DATA,    8'h3F, 32'h0, 1'b1, 8'h00}, // RAM write, top page
         '{FUNC_WRITE, REG_CONTROL, 8'hF0, 32'h0, 1'b1, 8'h00},
         '{FUNC_READ,  REG_CONTROL, 8'h00, 32'h0, 1'b1, 8'h70}, // transaction bit cleared
         '{FUNC_WRITE, REG_DATA,    8'h7C, 32'h0, 1'b1, 8'h00}, // low address bits all set
         '{FUNC_WRITE, REG_CONTROL, 8'h2A, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_DATA,    8'hA5, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'h0, 1'b1, 8'h00}, // stores to the last entry
         '{FUNC_WRITE, REG_DATA,    8'hBF, 32'h0, 1'b1, 8'h00}, // RAM read, top page
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_DATA,    8'h7C, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'h0, 1'b1, 8'h00},
         '{FUNC_READ,  REG_DATA,    8'h00, 32'h0, 1'b0, 8'h00}, // last entry read back
         '{FUNC_WRITE, REG_DATA,    8'h81, 32'h0, 1'b1, 8'h00}, // clock read, byte 0
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'hFFFF_FFFF, 1'b1, 8'h00},
         '{FUNC_READ,  REG_DATA,    8'h00, 32'h0, 1'b0, 8'h00},
         '{FUNC_WRITE, REG_DATA,    8'h0D, 32'h0, 1'b1, 8'h00}, // clock write is ignored
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'h0, 1'b1, 8'h00},
         '{FUNC_WRITE, REG_CONTROL, 8'h20, 32'h0, 1'b1, 8'h00},
         '{FUNC_READ,  REG_DATA,    8'h00, 32'h0, 1'b0, 8'h00}
      };

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_requests[i]) begin
         send_request(directed_requests[i]);
      end

      // Random phases. The offset is only written with the unit drained, and
      // each phase runs under a different mix of sender gaps and receiver stalls.
      for (int phase = 0; phase < 4; phase++) begin
         hold_until_drained();
         repeat (4) @(negedge clock);
         case (phase)
            0: begin
               offset = 32'hFFFF_FFFF;
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               offset = $urandom;
               send_idle_pct = 66;
               rsp_stall_pct = 0;
            end
            2: begin
               offset = 32'h0000_0000;
               send_idle_pct = 0;
               rsp_stall_pct = 66;
            end
            default: begin
               offset = 32'h8000_0000 | $urandom_range(255);
               send_idle_pct = 28;
               rsp_stall_pct = 28;
            end
         endcase
         program_clock_offset(offset);
         phase_end = requests_sent + ITEMS_PER_PHASE;
         while (requests_sent < phase_end) begin
            if ($urandom_range(99) == 0) begin
               hold_until_drained();
            end
            // A small pool of addresses makes reads land on written entries.
            addr = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(7));
            case ($urandom_range(9))
               0, 1, 2: battery_ram_access(1'b0, addr);
               3, 4:    battery_ram_access(1'b1, addr);
               5, 6:    clock_byte_access(1'b1, 2'($urandom));
               7:       clock_byte_access(1'b0, 2'($urandom));
               8: begin
                  // Broken sequence: a command whose follow-up control write
                  // may clear it or leave the sequencer mid-transaction.
                  bus_access(FUNC_WRITE, REG_DATA,
                             $urandom_range(1) ? (CMD_RAM_MATCH | 8'($urandom_range(7)))
                                               : (CMD_CLK_MATCH | 8'($urandom_range(3) << 2)),
                             $urandom);
                  bus_access(FUNC_WRITE, REG_CONTROL, 8'($urandom), $urandom);
               end
               default: begin
                  bus_access(1'($urandom), 1'($urandom), 8'($urandom), $urandom);
               end
            endcase
         end
      end

      hold_until_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_read_bytes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Guard against a hang anywhere in the handshakes.
   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rtcbr_pkg.sv
rtl/rtcbr_ram.sv
rtl/rtcbr_seq.sv
rtl/rtc_battery_ram_command_port_unit.sv
tb/sv/rtc_battery_ram_command_port_unit_tb.sv
